// File: sv/kpib_pkg.sv
package kpib_pkg;

  localparam int CODE_W  = 20;  // widest codeword: 32^4 - 1
  localparam int WIN_LEN = 4;

  localparam logic [2:0] CMD_COUNT = 3'd0;
  localparam logic [2:0] CMD_FINAL = 3'd1;
  localparam logic [2:0] CMD_PLACE = 3'd2;
  localparam logic [2:0] CMD_QUERY = 3'd3;
  localparam logic [2:0] CMD_CLEAR = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  localparam logic [1:0] REG_NUM_CODES   = 2'd0;
  localparam logic [1:0] REG_WORD_LENGTH = 2'd1;

  localparam logic [5:0] NC_RESET = 6'd24;
  localparam logic [2:0] WL_RESET = 3'd3;

  typedef struct packed {
    logic       shift;
    logic       restart;
    logic       clear;
    logic [7:0] residue;
  } win_ctl_t;

  typedef struct packed {
    logic              full;
    logic              busy;
    logic [CODE_W-1:0] cw;
    logic [15:0]       start;
  } win_sts_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [13:0] word_code;
    logic [19:0] slot;
    logic [15:0] sub;
    logic [15:0] seq;
    logic [20:0] offs;
    logic [20:0] cnt;
  } res_t;

endpackage

// File: sv/kpib_ram.sv
module kpib_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/kpib_window.sv
module kpib_window import kpib_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  win_ctl_t ctl,
  input  logic [5:0] nc,
  input  logic [2:0] wl,
  output win_sts_t sts
);

  logic [4:0]        win_r [WIN_LEN];
  logic [2:0]        fill_r;
  logic [15:0]       pos_r;
  logic [15:0]       start_r;
  logic              full_r;
  logic              busy_r;
  logic [1:0]        k_r;
  logic [CODE_W-1:0] acc_r;

  logic [2:0]  fill_base;
  logic [2:0]  fill_nxt;
  logic [15:0] pos_base;
  logic [4:0]  code;
  logic        full_nxt;

  always_comb begin
    fill_base = ctl.restart ? 3'd0 : fill_r;
    pos_base  = ctl.restart ? 16'd0 : pos_r;
    fill_nxt  = (fill_base < 3'd4) ? fill_base + 3'd1 : fill_base;
    full_nxt  = (fill_nxt >= wl);
    code      = ({2'b00, ctl.residue[5:0]} == ctl.residue && ctl.residue[5:0] < nc)
                ? ctl.residue[4:0] : 5'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WIN_LEN; i++) win_r[i] <= 5'd0;
      fill_r <= 3'd0;
      pos_r  <= 16'd0;
      full_r <= 1'b0;
      busy_r <= 1'b0;
    end else if (ctl.clear) begin
      for (int i = 0; i < WIN_LEN; i++) win_r[i] <= 5'd0;
      fill_r <= 3'd0;
      pos_r  <= 16'd0;
    end else if (ctl.shift) begin
      win_r[3] <= ctl.restart ? 5'd0 : win_r[2];
      win_r[2] <= ctl.restart ? 5'd0 : win_r[1];
      win_r[1] <= ctl.restart ? 5'd0 : win_r[0];
      win_r[0] <= code;
      fill_r   <= fill_nxt;
      full_r   <= full_nxt;
      busy_r   <= full_nxt;
      k_r      <= 2'(wl - 3'd1);
      acc_r    <= '0;
      if (full_nxt) begin
        start_r <= pos_base;
        pos_r   <= (pos_base != 16'hffff) ? pos_base + 16'd1 : pos_base;
      end else begin
        pos_r <= pos_base;
      end
    end else if (busy_r) begin
      // Horner step, oldest code first
      acc_r <= CODE_W'(acc_r * CODE_W'(nc)) + CODE_W'(win_r[k_r]);
      k_r   <= k_r - 2'd1;
      if (k_r == 2'd0) busy_r <= 1'b0;
    end
  end

  assign sts.full  = full_r;
  assign sts.busy  = busy_r;
  assign sts.cw    = acc_r;
  assign sts.start = start_r;

endmodule

// File: sv/kmer_position_index_builder.sv
// Word-position index builder, one block, counting sort.
// Input channel in_*: one command word per handshake (valid/stall). Output
// channel out_*: exactly one result word per command, in order.
// Config: cfg_we/cfg_index/cfg_wdata, index 0 = num_codes, 1 = word_length;
// write only while idle.
// Flow: one command at a time. Count and place go through a window shift,
// one Horner step per residue on the shared multiplier, a table read and a
// read-modify-write. Query reads the count and index tables. Finalize
// sweeps the count table once. Clear rewrites the count table. Reset: a
// clearing pass zeroes the count table; in_stall stays high meanwhile.
// Config writes are taken throughout.
// A finished result sits in the output register; the next command is taken
// while it waits, and the block holds in its final step only if the output
// register is still full when the next result is ready.
module kmer_position_index_builder import kpib_pkg::*; #(
  parameter int WORD_TABLE_DEPTH = 16384,
  parameter int MAX_POSITIONS    = 1048576
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [7:0]  in_residue,
  input  logic        in_seq_start,
  input  logic [15:0] in_seq_number,
  input  logic [13:0] in_word_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [13:0] out_word_code,
  output logic [19:0] out_slot_address,
  output logic [15:0] out_sub_offset,
  output logic [15:0] out_seq_number_out,
  output logic [20:0] out_start_offset,
  output logic [20:0] out_word_count,
  output logic [20:0] out_total_positions
);

  localparam int AW = $clog2(WORD_TABLE_DEPTH);
  localparam int CW = $clog2(MAX_POSITIONS + 1);
  localparam logic [AW:0] LAST = (AW+1)'(WORD_TABLE_DEPTH - 1);
  localparam logic [AW:0] DEPTH_C = (AW+1)'(WORD_TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_HORN, S_LOOK, S_EXEC, S_FIN, S_EMIT
  } state_t;

  state_t      state_r;
  logic [5:0]  nc_r;
  logic [2:0]  wl_r;
  logic [AW:0] cnt_r;
  logic        rd_pend_r;
  logic [AW-1:0] wr_addr_r;
  logic [CW-1:0] sum_r;
  logic [CW-1:0] total_r;
  logic [2:0]  cmd_r;
  logic [15:0] seq_r;
  logic [13:0] wi_r;
  logic        clr_emit_r;
  res_t        res_r;
  logic        out_valid_r;
  res_t        out_r;
  logic [20:0] out_total_r;

  logic [5:0]  nc_eff;
  logic [2:0]  wl_eff;
  win_ctl_t    win_ctl;
  win_sts_t    win_sts;
  logic        accept;
  logic        cw_in_table;
  logic        total_full;

  logic          cnt_we;
  logic [AW-1:0] cnt_waddr;
  logic [CW-1:0] cnt_wdata;
  logic [AW-1:0] cnt_raddr;
  logic [CW-1:0] cnt_q;
  logic          idx_we;
  logic [AW-1:0] idx_waddr;
  logic [2*CW-1:0] idx_wdata;
  logic [AW-1:0] idx_raddr;
  logic [2*CW-1:0] idx_q;
  logic [CW-1:0] fill_p;
  logic [CW-1:0] end_p;
  logic          place_ok;

  assign nc_eff = (nc_r > 6'd32) ? 6'd32 : nc_r;
  assign wl_eff = (wl_r == 3'd0) ? 3'd1 : ((wl_r > 3'd4) ? 3'd4 : wl_r);
  assign in_stall = (state_r != S_IDLE);
  assign accept = in_valid && (state_r == S_IDLE);
  assign cw_in_table = (32'(win_sts.cw) < 32'(WORD_TABLE_DEPTH));
  assign total_full = (32'(total_r) >= 32'(MAX_POSITIONS));
  assign fill_p = idx_q[CW-1:0];
  assign end_p  = idx_q[2*CW-1:CW];
  assign place_ok = (fill_p < end_p) && (32'(fill_p) < 32'(MAX_POSITIONS));

  always_comb begin
    win_ctl.shift   = accept && (in_command == CMD_COUNT || in_command == CMD_PLACE);
    win_ctl.restart = in_seq_start;
    win_ctl.clear   = accept && (in_command == CMD_FINAL || in_command == CMD_CLEAR);
    win_ctl.residue = in_residue;
  end

  kpib_window u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (win_ctl),
    .nc    (nc_eff),
    .wl    (wl_eff),
    .sts   (win_sts)
  );

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = AW'(win_sts.cw);
    cnt_wdata = cnt_q + CW'(1);
    idx_we    = 1'b0;
    idx_waddr = AW'(win_sts.cw);
    idx_wdata = {end_p, fill_p + CW'(1)};
    cnt_raddr = AW'(win_sts.cw);
    idx_raddr = AW'(win_sts.cw);
    case (state_r)
      S_IDLE: begin
        cnt_raddr = AW'(in_word_index);
        idx_raddr = AW'(in_word_index - 14'd1);
      end
      S_CLR: begin
        cnt_we    = 1'b1;
        cnt_waddr = cnt_r[AW-1:0];
        cnt_wdata = '0;
      end
      S_FIN: begin
        cnt_raddr = cnt_r[AW-1:0];
        idx_we    = rd_pend_r;
        idx_waddr = wr_addr_r;
        idx_wdata = {sum_r + cnt_q, sum_r};
      end
      S_EXEC: begin
        cnt_we = (cmd_r == CMD_COUNT) && !total_full;
        idx_we = (cmd_r == CMD_PLACE) && place_ok;
      end
      default: ;
    endcase
  end

  kpib_ram #(.WIDTH(CW), .DEPTH(WORD_TABLE_DEPTH)) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_q)
  );

  // each entry: {end of region = next word's offset, fill pointer}
  kpib_ram #(.WIDTH(2*CW), .DEPTH(WORD_TABLE_DEPTH)) u_index_ram (
    .clk   (clk),
    .we    (idx_we),
    .waddr (idx_waddr),
    .wdata (idx_wdata),
    .raddr (idx_raddr),
    .rdata (idx_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cnt_r       <= '0;
      clr_emit_r  <= 1'b0;
      total_r     <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      res_r       <= '0;
      nc_r        <= NC_RESET;
      wl_r        <= WL_RESET;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_NUM_CODES) nc_r <= cfg_wdata;
        else if (cfg_index == REG_WORD_LENGTH) wl_r <= cfg_wdata[2:0];
      end
      if (out_valid_r && !out_stall && state_r != S_EMIT) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r <= in_command;
            seq_r <= in_seq_number;
            wi_r  <= in_word_index;
            case (in_command)
              CMD_COUNT, CMD_PLACE: state_r <= S_HORN;
              CMD_FINAL: begin
                cnt_r     <= '0;
                rd_pend_r <= 1'b0;
                sum_r     <= '0;
                state_r   <= S_FIN;
              end
              CMD_QUERY: begin
                res_r.word_code <= in_word_index;
                if (32'(in_word_index) >= 32'(WORD_TABLE_DEPTH)) begin
                  res_r.status <= ST_RANGE;
                  state_r      <= S_EMIT;
                end else begin
                  state_r <= S_EXEC;
                end
              end
              CMD_CLEAR: begin
                total_r    <= '0;
                cnt_r      <= '0;
                clr_emit_r <= 1'b1;
                state_r    <= S_CLR;
              end
              default: state_r <= S_EMIT;
            endcase
          end
        end
        S_HORN: begin
          if (!win_sts.full) begin
            res_r.status <= ST_SHORT;
            state_r      <= S_EMIT;
          end else if (!win_sts.busy) begin
            res_r.word_code <= 14'(win_sts.cw);
            res_r.sub       <= win_sts.start;
            res_r.seq       <= seq_r;
            if (!cw_in_table) begin
              res_r.status <= ST_RANGE;
              state_r      <= S_EMIT;
            end else begin
              state_r <= S_LOOK;
            end
          end
        end
        S_LOOK: state_r <= S_EXEC;
        S_EXEC: begin
          case (cmd_r)
            CMD_COUNT: begin
              if (total_full) res_r.status <= ST_FULL;
              else total_r <= total_r + CW'(1);
            end
            CMD_PLACE: begin
              if (!place_ok) res_r.status <= ST_FULL;
              else res_r.slot <= 20'(fill_p);
            end
            default: begin
              res_r.offs <= (wi_r == 14'd0) ? 21'd0 : 21'(end_p);
              res_r.cnt  <= 21'(cnt_q);
            end
          endcase
          state_r <= S_EMIT;
        end
        S_FIN: begin
          rd_pend_r <= (cnt_r < DEPTH_C);
          wr_addr_r <= cnt_r[AW-1:0];
          if (rd_pend_r) sum_r <= sum_r + cnt_q;
          if (cnt_r < DEPTH_C) cnt_r <= cnt_r + 1'b1;
          else if (!rd_pend_r) state_r <= S_EMIT;
        end
        S_CLR: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == LAST) begin
            state_r    <= clr_emit_r ? S_EMIT : S_IDLE;
            clr_emit_r <= 1'b0;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || !out_stall) begin
            out_r       <= res_r;
            out_total_r <= 21'(total_r);
            out_valid_r <= 1'b1;
            res_r       <= '0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_r.status;
  assign out_word_code       = out_r.word_code;
  assign out_slot_address    = out_r.slot;
  assign out_sub_offset      = out_r.sub;
  assign out_seq_number_out  = out_r.seq;
  assign out_start_offset    = out_r.offs;
  assign out_word_count      = out_r.cnt;
  assign out_total_positions = out_total_r;

endmodule

// File: sv/kpib_checker.sv
module kpib_checker import kpib_pkg::*; #(
  parameter int MAX_POSITIONS = 1048576
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [19:0] out_slot_address,
  input logic [20:0] out_start_offset,
  input logic [20:0] out_word_count,
  input logic [20:0] out_total_positions
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("no clearing pass after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken while one is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status))
    else $error("stalled result word changed");

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_total_positions) <= 32'(MAX_POSITIONS))
    else $error("total beyond position store");

  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_SHORT |->
      out_slot_address == 20'd0 && out_start_offset == 21'd0 && out_word_count == 21'd0)
    else $error("short window result carries data");

endmodule

bind kmer_position_index_builder kpib_checker #(.MAX_POSITIONS(MAX_POSITIONS)) u_kpib_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_status          (out_status),
  .out_slot_address    (out_slot_address),
  .out_start_offset    (out_start_offset),
  .out_word_count      (out_word_count),
  .out_total_positions (out_total_positions)
);

// File: test/tb_kmer_position_index_builder.sv
module tb_kmer_position_index_builder;
  import kpib_pkg::*;

  localparam int TABLE_DEPTH = 16384;
  localparam int POS_LIMIT = 1048576;
  // commands 5..7 carry no meaning and must be ignored
  localparam logic [2:0] CMD_IGNORED_LO = 3'd5;
  localparam logic [2:0] CMD_IGNORED_HI = 3'd7;
  localparam int STALL_LIMIT = 60000;

  typedef struct packed {
    logic [1:0]  status;
    logic [13:0] word_code;
    logic [19:0] slot;
    logic [15:0] sub;
    logic [15:0] seq;
    logic [20:0] offs;
    logic [20:0] cnt;
    logic [20:0] total;
  } index_result_t;

  class index_scoreboard;
    int unsigned n_codes, w_len;
    int unsigned win[4];
    int unsigned win_fill, win_pos;
    int unsigned counts[TABLE_DEPTH];
    int unsigned offsets[TABLE_DEPTH + 1];
    int unsigned fill_ptr[TABLE_DEPTH];
    int unsigned total;
    index_result_t pending[$];
    int errors;
    int checked;

    function new();
      n_codes = NC_RESET;
      w_len = WL_RESET;
      restart();
      foreach (counts[i]) counts[i] = 0;
      foreach (offsets[i]) offsets[i] = 0;
      foreach (fill_ptr[i]) fill_ptr[i] = 0;
      total = 0;
      errors = 0;
      checked = 0;
    endfunction

    function void restart();
      foreach (win[i]) win[i] = 0;
      win_fill = 0;
      win_pos = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [5:0] val);
      if (idx == REG_NUM_CODES) n_codes = val;
      else if (idx == REG_WORD_LENGTH) w_len = val[2:0];
    endfunction

    function void note_word(logic [2:0] cmd, logic [7:0] r, logic ss, logic [15:0] sn,
                            logic [13:0] wi);
      index_result_t e;
      int unsigned nc, wl, code, cw, sum;
      int k;
      e = '0;
      case (cmd)
        CMD_COUNT, CMD_PLACE: begin
          nc = (n_codes > 32) ? 32 : n_codes;
          wl = (w_len == 0) ? 1 : ((w_len > 4) ? 4 : w_len);
          code = (r < nc) ? r : 0;
          if (ss) restart();
          win[3] = win[2];
          win[2] = win[1];
          win[1] = win[0];
          win[0] = code & 31;
          if (win_fill < 4) win_fill++;
          if (win_fill < wl) begin
            e.status = ST_SHORT;
          end else begin
            cw = 0;
            for (k = wl - 1; k >= 0; k--) cw = cw * nc + win[k];
            e.word_code = cw[13:0];
            e.sub = win_pos[15:0];
            e.seq = sn;
            if (win_pos < 65535) win_pos++;
            if (cw >= TABLE_DEPTH) begin
              e.status = ST_RANGE;
            end else if (cmd == CMD_COUNT) begin
              if (total >= POS_LIMIT) e.status = ST_FULL;
              else begin
                counts[cw]++;
                total++;
              end
            end else begin
              if (fill_ptr[cw] >= offsets[cw + 1] || fill_ptr[cw] >= POS_LIMIT) begin
                e.status = ST_FULL;
              end else begin
                e.slot = fill_ptr[cw][19:0];
                fill_ptr[cw]++;
              end
            end
          end
        end
        CMD_FINAL: begin
          sum = 0;
          for (k = 0; k < TABLE_DEPTH; k++) begin
            offsets[k] = sum;
            fill_ptr[k] = sum;
            sum += counts[k];
          end
          offsets[TABLE_DEPTH] = sum;
          restart();
        end
        CMD_QUERY: begin
          e.word_code = wi;
          e.offs = offsets[wi];
          e.cnt = counts[wi];
        end
        CMD_CLEAR: begin
          foreach (counts[i]) counts[i] = 0;
          total = 0;
          restart();
        end
        default: ;
      endcase
      e.total = total[20:0];
      pending.push_back(e);
    endfunction

    function void compare(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(index_result_t got);
      index_result_t e;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word: expected none, got %h", $time, got);
        return;
      end
      e = pending.pop_front();
      compare("status", e.status, got.status);
      compare("word_code", e.word_code, got.word_code);
      compare("slot_address", e.slot, got.slot);
      compare("sub_offset", e.sub, got.sub);
      compare("seq_number_out", e.seq, got.seq);
      compare("start_offset", e.offs, got.offs);
      compare("word_count", e.cnt, got.cnt);
      compare("total_positions", e.total, got.total);
    endfunction
  endclass

  logic clk, rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [5:0] cfg_wdata;
  logic in_valid, in_stall;
  logic [2:0] in_command;
  logic [7:0] in_residue;
  logic in_seq_start;
  logic [15:0] in_seq_number;
  logic [13:0] in_word_index;
  logic out_valid, out_stall;
  logic [1:0] out_status;
  logic [13:0] out_word_code;
  logic [19:0] out_slot_address;
  logic [15:0] out_sub_offset, out_seq_number_out;
  logic [20:0] out_start_offset, out_word_count, out_total_positions;

  kmer_position_index_builder DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_residue(in_residue), .in_seq_start(in_seq_start),
    .in_seq_number(in_seq_number), .in_word_index(in_word_index),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_word_code(out_word_code), .out_slot_address(out_slot_address),
    .out_sub_offset(out_sub_offset), .out_seq_number_out(out_seq_number_out),
    .out_start_offset(out_start_offset), .out_word_count(out_word_count),
    .out_total_positions(out_total_positions)
  );

  index_scoreboard sb = new();
  bit quiet;
  int words_sent;
  int idle_cycles;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_status, out_word_code, out_slot_address, out_sub_offset,
                       out_seq_number_out, out_start_offset, out_word_count,
                       out_total_positions});
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("kmer_position_index_builder regression: fail");
      $finish;
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  task automatic send_word(logic [2:0] cmd, logic [7:0] r, logic ss, logic [15:0] sn,
                           logic [13:0] wi);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_command <= cmd;
    in_residue <= r;
    in_seq_start <= ss;
    in_seq_number <= sn;
    in_word_index <= wi;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_word(cmd, r, ss, sn, wi);
    words_sent++;
  endtask

  task automatic send_query(logic [13:0] wi);
    send_word(CMD_QUERY, $urandom, $urandom, $urandom, wi);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [5:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // clear, count pass over random sequences, finalize, then replay them as a place pass with queries
  task automatic run_round(int nseq);
    logic [7:0] res_q[$];
    logic ss_q[$];
    logic [15:0] sn_q[$];
    int len;
    logic [15:0] sn;
    int top;
    top = (sb.n_codes > 32) ? 34 : sb.n_codes + 2;
    for (int s = 0; s < nseq; s++) begin
      len = $urandom_range(0, 12);
      sn = $urandom;
      for (int i = 0; i < len; i++) begin
        res_q.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, top)));
        ss_q.push_back(i == 0);
        sn_q.push_back(sn);
      end
    end
    send_word(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
    foreach (res_q[i]) begin
      if ($urandom_range(0, 30) == 0)
        send_word(3'($urandom_range(CMD_IGNORED_LO, CMD_IGNORED_HI)), $urandom, $urandom,
                  $urandom, $urandom);
      send_word(CMD_COUNT, res_q[i], ss_q[i], sn_q[i], $urandom);
    end
    send_word(CMD_FINAL, $urandom, $urandom, $urandom, $urandom);
    foreach (res_q[i]) begin
      if ($urandom_range(0, 15) == 0) send_query($urandom_range(0, 1200));
      if ($urandom_range(0, 40) == 0)
        send_word(CMD_PLACE, $urandom, $urandom, $urandom, $urandom);
      send_word(CMD_PLACE, res_q[i], ss_q[i], sn_q[i], $urandom);
    end
    repeat (10) send_query(($urandom_range(0, 1)) ? 14'($urandom) : 14'($urandom_range(0, 1200)));
  endtask

  initial begin
    logic [5:0] nc_set[$] = '{6'd1, 6'd32, 6'd0, 6'd45, 6'd4, 6'd20, 6'd32, 6'd7, 6'd63};
    logic [5:0] wl_set[$] = '{6'd1, 6'd4, 6'd2, 6'd0, 6'd7, 6'd2, 6'd3, 6'd4, 6'd5};
    rst_n = 1'b0;
    quiet = 1'b0;
    words_sent = 0;
    idle_cycles = 0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_command = CMD_COUNT;
    in_residue = '0;
    in_seq_start = 1'b0;
    in_seq_number = '0;
    in_word_index = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset config (24 codes, words of 3)
    send_word(CMD_COUNT, 8'd1, 1'b1, 16'hFFFF, '0);
    send_word(CMD_COUNT, 8'd23, 1'b0, 16'hFFFF, '0);
    send_word(CMD_COUNT, 8'd24, 1'b0, 16'hFFFF, '0);   // out of alphabet -> 0
    send_word(CMD_COUNT, 8'd255, 1'b0, 16'hFFFF, '0);
    send_word(CMD_COUNT, 8'd5, 1'b1, 16'd0, '0);       // short sequence
    send_word(CMD_COUNT, 8'd23, 1'b1, 16'h8000, '0);
    send_word(CMD_COUNT, 8'd23, 1'b0, 16'h8000, '0);
    send_word(CMD_COUNT, 8'd23, 1'b0, 16'h8000, '0);   // top codeword
    send_word(3'd5, 8'd1, 1'b1, 16'd1, 14'd1);
    send_word(3'd6, 8'd1, 1'b0, 16'd1, 14'd1);
    send_word(3'd7, 8'd1, 1'b0, 16'd1, 14'd1);
    send_word(CMD_FINAL, '0, 1'b0, '0, '0);
    send_query(14'd576);
    send_query(14'd13823);
    send_query(14'd16383);
    send_word(CMD_PLACE, 8'd1, 1'b1, 16'hFFFF, '0);
    send_word(CMD_PLACE, 8'd23, 1'b0, 16'hFFFF, '0);
    send_word(CMD_PLACE, 8'd24, 1'b0, 16'hFFFF, '0);
    send_word(CMD_PLACE, 8'd255, 1'b0, 16'hFFFF, '0);
    send_word(CMD_PLACE, 8'd9, 1'b1, 16'd3, '0);
    send_word(CMD_PLACE, 8'd9, 1'b0, 16'd3, '0);
    send_word(CMD_PLACE, 8'd9, 1'b0, 16'd3, '0);       // word never counted -> full
    send_word(CMD_CLEAR, '0, 1'b0, '0, '0);
    send_query(14'd576);
    wait_drained();

    foreach (nc_set[i]) begin
      if (i >= nc_set.size() - 2) quiet = 1'b1;
      write_reg(REG_NUM_CODES, nc_set[i]);
      write_reg(REG_WORD_LENGTH, wl_set[i]);
      run_round(15);
      wait_drained();
    end

    $display("sent %0d command words, checked %0d results over %0d alphabet/word settings",
             words_sent, sb.checked, nc_set.size() + 1);
    $display("covered count, finalize, place, query, clear and ignored commands");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("kmer_position_index_builder regression: pass");
    end else begin
      $display("kmer_position_index_builder regression: fail");
    end
    $finish;
  end
endmodule

// File: kmer_position_index_builder.f
sv/kpib_pkg.sv
sv/kpib_ram.sv
sv/kpib_window.sv
sv/kmer_position_index_builder.sv
sv/kpib_checker.sv
test/tb_kmer_position_index_builder.sv
